FILE: hdl/hkrt_pkg.sv
// Shared types and constants for the keyboard report rollover table.
// Used by hkrt_update, the top level and the port checker; depends on nothing.

package hkrt_pkg;

	localparam int SLOT_COUNT = 10;
	localparam int OUT_SLOTS  = 10;
	localparam int KEY_W      = 8;
	localparam int MOD_W      = 8;

	localparam int IN_TDATA_W  = KEY_W;
	localparam int OUT_TDATA_W = MOD_W + OUT_SLOTS * KEY_W;

	// Usage codes 224..231 are the eight modifier keys.
	localparam logic [4:0] MOD_PREFIX = 5'b11100;

	localparam logic ACT_PRESS   = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	typedef logic [KEY_W-1:0] key_t;

	typedef struct packed {
		logic [MOD_W-1:0]            mods;
		key_t [SLOT_COUNT-1:0]       slots;
	} report_t;

endpackage

FILE: hdl/hkrt_update.sv
// Next-report logic: applies one key event to the current report.
// Depends on hkrt_pkg.

module hkrt_update import hkrt_pkg::*; (
	input  logic    action,
	input  key_t    key_code,
	input  report_t cur,
	output report_t nxt
);

	logic [SLOT_COUNT-1:0] match;
	logic [SLOT_COUNT-1:0] seen;
	logic [SLOT_COUNT-1:0] occ_before;
	key_t [SLOT_COUNT-1:0] up;
	logic                  is_mod;
	logic                  present;
	logic                  full;

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			match[i] = (cur.slots[i] == key_code);
		end
		// seen marks the first matching slot and every slot after it.
		seen[0] = match[0];
		for (int i = 1; i < SLOT_COUNT; i++) begin
			seen[i] = seen[i-1] | match[i];
		end
		occ_before[0] = 1'b1;
		for (int i = 1; i < SLOT_COUNT; i++) begin
			occ_before[i] = (cur.slots[i-1] != '0);
		end
		for (int i = 0; i < SLOT_COUNT - 1; i++) begin
			up[i] = cur.slots[i+1];
		end
		up[SLOT_COUNT-1] = '0;

		is_mod  = (key_code[KEY_W-1:3] == MOD_PREFIX);
		present = |match;
		full    = (cur.slots[SLOT_COUNT-1] != '0);

		nxt = cur;
		if (is_mod) begin
			if (action == ACT_RELEASE) begin
				nxt.mods = cur.mods & ~(MOD_W'(1) << key_code[2:0]);
			end else begin
				nxt.mods = cur.mods | (MOD_W'(1) << key_code[2:0]);
			end
		end else if (key_code != '0) begin
			if (action == ACT_RELEASE) begin
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (seen[i]) begin
						nxt.slots[i] = up[i];
					end
				end
			end else if (!present) begin
				if (full) begin
					// Oldest key drops out; the new one goes last.
					nxt.slots = up;
					nxt.slots[SLOT_COUNT-1] = key_code;
				end else begin
					// The table is packed, so the first empty slot follows an occupied one.
					for (int i = 0; i < SLOT_COUNT; i++) begin
						if (cur.slots[i] == '0 && occ_before[i]) begin
							nxt.slots[i] = key_code;
						end
					end
				end
			end
		end
	end

endmodule

FILE: hdl/hid_key_rollover_table_top.sv
// Keyboard report keeper with key rollover: top level with stream ports.
// Depends on hkrt_pkg and hkrt_update.

// Every key event taken on the input stream produces one full report on the
// output stream: the modifier byte and ten key slots, oldest key first, zero
// where empty. An event is registered on entry and applied, once the output
// register is free, by a single pass of compare-and-shift logic over the slot
// table; the report register is also the output register. The block takes one
// event per cycle as long as each report is taken; an event passes through the
// input register and then the report register. While a report waits, one more
// event can be held in the input register. Reset clears the report to all zero.

module hid_key_rollover_table_top import hkrt_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // key_code[7:0]
	input  logic                   s_axis_tuser,   // action (0 press, 1 release)
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata    // modifiers, slot_0 .. slot_9
);

	logic    valid_s1;
	logic    action_s1;
	key_t    code_s1;
	logic    out_valid_q;
	report_t report_q;
	report_t report_nxt;
	logic    advance;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			action_s1 <= s_axis_tuser;
			code_s1   <= s_axis_tdata;
		end
	end

	hkrt_update u_update (
		.action   (action_s1),
		.key_code (code_s1),
		.cur      (report_q),
		.nxt      (report_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			report_q    <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				report_q    <= report_nxt;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;

	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[MOD_W-1:0] = report_q.mods;
		for (int k = 0; k < OUT_SLOTS; k++) begin
			if (k < SLOT_COUNT) begin
				m_axis_tdata[MOD_W + k*KEY_W +: KEY_W] = report_q.slots[k];
			end
		end
	end

endmodule

FILE: hdl/hkrt_checker.sv
// Port-level checks for the rollover table top level, attached by bind.
// Depends on hkrt_pkg and hid_key_rollover_table_top.

module hkrt_checker import hkrt_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// A stalled report stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("report changed while stalled");

	// With no report waiting, the input side is never blocked.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input blocked with empty output");

	// The table is packed: an empty oldest slot means every slot is empty.
	a_packed_head: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[15:8] == 8'd0 |-> m_axis_tdata[87:16] == '0)
		else $error("key table not packed");

	// An empty slot before the newest one means the newest slot is empty too.
	a_packed_tail: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[79:72] == 8'd0 |-> m_axis_tdata[87:80] == 8'd0)
		else $error("gap before newest slot");

endmodule

bind hid_key_rollover_table_top hkrt_checker u_hkrt_checker (.*);
